/* design/deq_pkg.sv */
// Package for the double-ended queue: command codes and the request and
// result structures. No dependencies; imported by double_ended_queue.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // Command codes; codes six and seven act as a query.
  typedef enum logic [2:0] {
    CMD_QUERY      = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_REVERSE    = 3'd5
  } cmd_e;

  // One request: a command and the value that a push stores.
  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] push_value;
  } req_t;

  // One result: the queue as it stands after the request.
  typedef struct packed {
    logic [63:0] front_value;
    logic [63:0] back_value;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic        push_dropped;
  } res_t;

endpackage

`default_nettype wire

/* design/double_ended_queue.sv */
// Bounded double-ended queue of 64-bit values held in a circular store.
// Depends on deq_pkg for the command codes and the request/result structs.
//
//   Channel   Ports                   Handshake
//   request   start_i, busy_o, req_i  taken when start_i is high and busy_o low
//   result    done_o, res_o           valid for the one cycle that done_o is high
//
// Every request is taken in the cycle it is offered (busy_o stays low), so one
// request per cycle is sustained. Its result appears in the next cycle, set by the
// registered read of the slot store, with the pushed value forwarded when it
// lands in a slot being read. Reset empties the queue at once; the slots
// themselves are not cleared. The receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire deq_pkg::req_t req_i,
  output logic               done_o,
  output deq_pkg::res_t      res_o
);

  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // Queue state: lowest occupied slot, fill level and orientation.
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rev_q, rev_d;

  // Result-side registers.
  logic          done_q;
  logic [CW-1:0] res_cnt_q;
  logic          res_rev_q;
  logic          drop_q, drop_d;
  logic          byp_lo_q, byp_hi_q;
  logic [63:0]   byp_data_q;
  logic [63:0]   rd_lo_q, rd_hi_q;

  // Slot store.
  logic [63:0]   mem [DEPTH];

  logic          accept;
  logic          full, empty, low_side;
  logic          wr_en;
  logic [AW-1:0] wr_addr, lo_addr, hi_addr;
  logic [AW:0]   tail_sum, hi_sum;
  logic [63:0]   low_val, high_val;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign full  = (cnt_q == FULL_CNT);
  assign empty = (cnt_q == '0);

  // Physical slot just past the high end, wrapped by one compare-subtract.
  assign tail_sum = (AW + 1)'(head_q) + (AW + 1)'(cnt_q);

  // Next state, the slot written and whether the push was refused.
  always_comb begin
    head_d   = head_q;
    cnt_d    = cnt_q;
    rev_d    = rev_q;
    drop_d   = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = head_q;
    low_side = 1'b0;
    case (req_i.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        low_side = ((req_i.cmd == CMD_PUSH_FRONT) == ~rev_q);
        if (full) begin
          drop_d = 1'b1;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CW'(1);
          if (low_side) begin
            head_d  = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
            wr_addr = head_d;
          end else begin
            wr_addr = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        low_side = ((req_i.cmd == CMD_POP_FRONT) == ~rev_q);
        if (!empty) begin
          cnt_d = cnt_q - CW'(1);
          if (low_side) begin
            head_d = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
          end
        end
      end
      CMD_REVERSE: begin
        rev_d = ~rev_q;
      end
      default: begin
      end
    endcase
  end

  // Slots at the two ends after the request.
  assign hi_sum  = (AW + 1)'(head_d) + (AW + 1)'(cnt_d) - (AW + 1)'(1);
  assign lo_addr = head_d;
  assign hi_addr = (hi_sum >= DEPTH_W) ? AW'(hi_sum - DEPTH_W) : AW'(hi_sum);

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      rev_q  <= 1'b0;
    end else if (accept) begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      rev_q  <= rev_d;
    end
  end

  // Slot store: one write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= req_i.push_value;
    end
    if (accept) begin
      rd_lo_q <= mem[lo_addr];
      rd_hi_q <= mem[hi_addr];
    end
  end

  // Result control, including forwarding of a value written in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      res_cnt_q <= '0;
      res_rev_q <= 1'b0;
      drop_q    <= 1'b0;
      byp_lo_q  <= 1'b0;
      byp_hi_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        res_cnt_q <= cnt_d;
        res_rev_q <= rev_d;
        drop_q    <= drop_d;
        byp_lo_q  <= wr_en && (wr_addr == lo_addr);
        byp_hi_q  <= wr_en && (wr_addr == hi_addr);
      end
    end
  end

  // Payload of the forwarded push value.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byp_data_q <= req_i.push_value;
    end
  end

  // Result assembly: empty queue reads zero at both ends.
  always_comb begin
    low_val  = byp_lo_q ? byp_data_q : rd_lo_q;
    high_val = byp_hi_q ? byp_data_q : rd_hi_q;
    if (res_cnt_q == '0) begin
      low_val  = '0;
      high_val = '0;
    end
    res_o.front_value  = res_rev_q ? high_val : low_val;
    res_o.back_value   = res_rev_q ? low_val : high_val;
    res_o.entry_count  = 5'(res_cnt_q);
    res_o.is_empty     = (res_cnt_q == '0);
    res_o.push_dropped = drop_q;
  end

  assign done_o = done_q;

`ifndef SYNTHESIS
  // The fill level never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FULL_CNT)
    else $error("queue count exceeds depth");

  // Every accepted request gives exactly one result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> done_o)
    else $error("result missing after request");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !accept |=> !done_o)
    else $error("result without request");

  // A refused push is reported only with a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.push_dropped) |-> (res_cnt_q == FULL_CNT))
    else $error("push dropped while queue not full");
`endif

endmodule

`default_nettype wire

/* verif/double_ended_queue_tb.sv */
// Self-checking testbench for double_ended_queue: directed and random requests
// against a behavioural copy of the deque. Depends on deq_pkg and the block.
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int DEPTH = 16;

  // Spare command codes; the block treats them as a query.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic done_o;
  res_t res_o;

  // Behavioural deque: circular store, head pointer, count, orientation.
  logic [63:0] model_slots [DEPTH];
  logic [3:0]  model_head;
  logic [4:0]  model_count;
  logic        model_reversed;

  res_t expected_views[$];
  int   mismatch_count;
  bit   idling_on;

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Applies one command to the deque copy and returns the view it leaves.
  function automatic res_t predict_queue_step(logic [2:0] cmd, logic [63:0] value);
    res_t       view;
    logic [3:0] tail;
    view = '0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (model_count >= DEPTH) begin
          view.push_dropped = 1'b1;
        end else begin
          // A push at the front of a reversed deque lands at the physical high end.
          if ((cmd == CMD_PUSH_FRONT) ^ model_reversed) begin
            model_head = model_head - 4'd1;
            model_slots[model_head] = value;
          end else begin
            model_slots[model_head + model_count[3:0]] = value;
          end
          model_count = model_count + 5'd1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (model_count != 0) begin
          if ((cmd == CMD_POP_FRONT) ^ model_reversed) begin
            model_head = model_head + 4'd1;
          end
          model_count = model_count - 5'd1;
        end
      end
      CMD_REVERSE: begin
        model_reversed = ~model_reversed;
      end
      default: begin
      end
    endcase
    // An empty deque shows zero at both ends.
    if (model_count != 0) begin
      tail = model_head + model_count[3:0] - 4'd1;
      view.front_value = model_reversed ? model_slots[tail] : model_slots[model_head];
      view.back_value  = model_reversed ? model_slots[model_head] : model_slots[tail];
    end
    view.entry_count = model_count;
    view.is_empty    = (model_count == 0);
    return view;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // Predicts each accepted request and checks each result against the oldest
  // prediction. Values sampled here are those from before the clock edge.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_views.push_back(predict_queue_step(req_i.cmd, req_i.push_value));
      end
      if (done_o) begin
        if (expected_views.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_views.pop_front();
          check_field("front_value", want.front_value, res_o.front_value);
          check_field("back_value", want.back_value, res_o.back_value);
          check_field("entry_count", want.entry_count, res_o.entry_count);
          check_field("is_empty", want.is_empty, res_o.is_empty);
          check_field("push_dropped", want.push_dropped, res_o.push_dropped);
        end
      end
    end
  end

  // Offers one request, waits until it is taken, then idles now and then.
  task automatic send_request(logic [2:0] cmd, logic [63:0] value);
    start_i <= 1'b1;
    req_i   <= {cmd, value};
    do @(posedge clk_i); while (busy_o);
    if (idling_on && $urandom_range(99) < 9) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return '1;
    if (pick < 14) return '0;
    return {$urandom(), $urandom()};
  endfunction

  // Every command but the pushes on an empty deque, the spare codes included.
  task automatic test_empty_queue();
    send_request(CMD_QUERY, random_value());
    send_request(CMD_POP_FRONT, random_value());
    send_request(CMD_POP_BACK, random_value());
    send_request(CMD_REVERSE, random_value());
    send_request(CMD_UNUSED_LO, random_value());
    send_request(CMD_UNUSED_HI, random_value());
  endtask

  // Fill to capacity from both ends, overflow at both ends, then reverse and pop.
  task automatic test_fill_and_overflow();
    send_request(CMD_PUSH_FRONT, '1);
    send_request(CMD_PUSH_BACK, '0);
    for (int i = 0; i < DEPTH - 2; i++) begin
      send_request(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                   i[0] ? 64'hAAAA_AAAA_AAAA_AAAA : (64'h5555_5555_5555_5555 ^ i));
    end
    send_request(CMD_PUSH_FRONT, 64'h0123_4567_89AB_CDEF);
    send_request(CMD_PUSH_BACK, 64'hFEDC_BA98_7654_3210);
    send_request(CMD_REVERSE, random_value());
    send_request(CMD_POP_FRONT, random_value());
    send_request(CMD_POP_BACK, random_value());
  endtask

  // Random traffic in bursts that lean towards filling, draining or neither,
  // so the deque keeps passing through full, empty and the one-value states.
  task automatic test_random_traffic(int items, bit with_idling);
    int          push_pct;
    int          roll;
    logic [2:0]  cmd;
    idling_on = with_idling;
    push_pct  = 50;
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 75;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      end else if (roll < 92) begin
        cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
      end else begin
        case ($urandom_range(3))
          0:       cmd = CMD_QUERY;
          1, 2:    cmd = CMD_REVERSE;
          default: cmd = $urandom_range(1) ? CMD_UNUSED_LO : CMD_UNUSED_HI;
        endcase
      end
      send_request(cmd, random_value());
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    req_i          = '0;
    mismatch_count = 0;
    idling_on      = 1'b1;
    model_head     = '0;
    model_count    = '0;
    model_reversed = 1'b0;
    for (int i = 0; i < DEPTH; i++) model_slots[i] = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_fill_and_overflow();
    test_random_traffic(160, 1'b0);
    test_random_traffic(560, 1'b1);

    // Let the last results arrive before judging the run.
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake or a result that never comes.
  initial begin
    #1ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
design/deq_pkg.sv
design/double_ended_queue.sv
verif/double_ended_queue_tb.sv
